@@ src/fstm_pkg.sv @@
// Shared types and constants of the flat span texture mapper.
`default_nettype none

package fstm_pkg;

  // Field widths of the request and result channels
  localparam int OP_W     = 2;
  localparam int TADDR_W  = 13;
  localparam int TVAL_W   = 8;
  localparam int ROW_W    = 10;
  localparam int COL_W    = 11;
  localparam int COUNT_W  = 7;
  localparam int COORD_W  = 32;
  localparam int SEL_W    = 5;
  localparam int COLOUR_W = 8;

  // 16.16 fixed point
  localparam int FRAC_BITS = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_DRAW       = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_TEXEL = 2'd1;
  localparam logic [OP_W-1:0] OP_LOAD_SHADE = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

endpackage

`default_nettype wire

@@ src/fstm_in_if.sv @@
// Request channel of the span mapper: draw and load requests.
`default_nettype none

interface fstm_in_if import fstm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            operation;
  logic [TADDR_W-1:0]         table_address;
  logic [TVAL_W-1:0]          table_value;
  logic [ROW_W-1:0]           span_row;
  logic [COL_W-1:0]           first_column;
  logic [COUNT_W-1:0]         pixel_count;
  logic signed [COORD_W-1:0]  start_u;
  logic signed [COORD_W-1:0]  start_v;
  logic signed [COORD_W-1:0]  step_u;
  logic signed [COORD_W-1:0]  step_v;
  logic [SEL_W-1:0]           shade_select;

  modport source (
    output valid, operation, table_address, table_value, span_row, first_column,
           pixel_count, start_u, start_v, step_u, step_v, shade_select,
    input  ready
  );

  modport sink (
    input  valid, operation, table_address, table_value, span_row, first_column,
           pixel_count, start_u, start_v, step_u, step_v, shade_select,
    output ready
  );
endinterface

`default_nettype wire

@@ src/fstm_out_if.sv @@
// Result channel of the span mapper: one request per drawn pixel.
`default_nettype none

interface fstm_out_if import fstm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [COL_W-1:0]    pixel_column;
  logic [ROW_W-1:0]    pixel_row;
  logic [COLOUR_W-1:0] pixel_colour;
  logic                last_pixel;

  modport source (
    output valid, pixel_column, pixel_row, pixel_colour, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, pixel_column, pixel_row, pixel_colour, last_pixel,
    output ready
  );
endinterface

`default_nettype wire

@@ src/flat_span_texture_mapper_core.sv @@
// Top level of the flat span texture mapper: span walker and lookup pipeline.
//
// - in_ch carries requests: draw span, load texel, load shade entry. A load
//   writes one byte into the tile or the shade store when accepted, if its
//   address is in range; no result. Codes other than the three are dropped.
// - A draw walks pixel_count pixels (saturated to SPAN_MAX) and issues one
//   out_ch request per pixel: column, row, shaded colour and a last flag on
//   the final pixel. A zero count gives no result.
// - A draw's first pixel passes the walker registers, the texel RAM read and
//   the shade RAM read, then one pixel per cycle follows unless out_ch stalls.
// - Throughput: one pixel per cycle while out_ch is ready, set by the single
//   read port of each RAM. A draw holds in_ch.ready low until its last pixel
//   has left the texel stage; a load leaves in_ch.ready high.
// - in_ch.ready needs the walker idle and the texel stage empty; the last
//   pixel of a span may still wait on out_ch when the next request is taken.
// - A receiver stall holds the walker and the whole pipeline; the shade RAM
//   read register is the output register, so nothing is lost or repeated.
// - Reset clears the walker and pipeline valids only. Both stores hold
//   undefined data until written; no clearing pass is made.
`default_nettype none

module flat_span_texture_mapper_core import fstm_pkg::*; #(
  parameter int SPAN_MAX     = 64,
  parameter int SHADE_TABLES = 32,
  parameter int TILE_BITS    = 6
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  fstm_in_if.sink     in_ch,
  fstm_out_if.source  out_ch
);

  localparam int TEX_AW     = 2 * TILE_BITS;
  localparam int TILE_SIZE  = 1 << TEX_AW;
  localparam int SHADE_SIZE = SHADE_TABLES * 256;
  localparam int SH_AW      = $clog2(SHADE_SIZE);
  localparam int CNT_W      = $clog2(SPAN_MAX + 1);

  state_t state_r, state_nxt;

  logic in_accept;
  logic draw_start;
  logic advance;
  logic step_go;
  logic tex_wr_en;
  logic sh_wr_en;

  // walker state
  logic [COORD_W-1:0] u_r, v_r, du_r, dv_r;
  logic [COORD_W-1:0] u_nxt, v_nxt;
  logic [COL_W-1:0]   col_r;
  logic [ROW_W-1:0]   row_r;
  logic [CNT_W-1:0]   remain_r;
  logic [SH_AW-1:0]   base_r;

  // lookup pipeline
  logic               s1_valid_r, s2_valid_r;
  logic [COL_W-1:0]   s1_col_r, s2_col_r;
  logic [ROW_W-1:0]   s1_row_r, s2_row_r;
  logic               s1_last_r, s2_last_r;

  logic [CNT_W-1:0]   count_sat;
  logic [6:0]         sel_sat;

  logic [TEX_AW-1:0]   tex_rd_addr;
  logic [TVAL_W-1:0]   tex_rd_data;
  logic [SH_AW-1:0]    sh_rd_addr;
  logic [COLOUR_W-1:0] sh_rd_data;

  assign in_accept = in_ch.valid && in_ch.ready;
  assign advance   = !s2_valid_r || out_ch.ready;

  assign draw_start = in_accept && (in_ch.operation == OP_DRAW) &&
                      (in_ch.pixel_count != '0);

  // request decode: loads write straight into the stores
  always_comb begin
    tex_wr_en = 1'b0;
    sh_wr_en  = 1'b0;
    unique case (in_ch.operation)
      OP_LOAD_TEXEL: tex_wr_en = in_accept && (32'(in_ch.table_address) < TILE_SIZE);
      OP_LOAD_SHADE: sh_wr_en  = in_accept && (32'(in_ch.table_address) < SHADE_SIZE);
      default: begin
        tex_wr_en = 1'b0;
        sh_wr_en  = 1'b0;
      end
    endcase
  end

  // span setup: saturate count and shade table
  assign count_sat = (in_ch.pixel_count > 7'(SPAN_MAX)) ? CNT_W'(SPAN_MAX)
                                                        : CNT_W'(in_ch.pixel_count);
  assign sel_sat = ({2'b00, in_ch.shade_select} >= 7'(SHADE_TABLES)) ?
                   7'(SHADE_TABLES - 1) : {2'b00, in_ch.shade_select};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (draw_start) state_nxt = ST_WALK;
      ST_WALK: if (advance && (remain_r == CNT_W'(1))) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE) && !s1_valid_r;
    step_go     = (state_r == ST_WALK) && advance;
  end

  // step unit: one coordinate step per pixel
  assign u_nxt = u_r + du_r;
  assign v_nxt = v_r + dv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (advance) begin
        s1_valid_r <= step_go;
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (draw_start) begin
      u_r      <= in_ch.start_u;
      v_r      <= in_ch.start_v;
      du_r     <= in_ch.step_u;
      dv_r     <= in_ch.step_v;
      col_r    <= in_ch.first_column;
      row_r    <= in_ch.span_row;
      remain_r <= count_sat;
      base_r   <= SH_AW'(sel_sat) << 8;
    end else if (step_go) begin
      u_r      <= u_nxt;
      v_r      <= v_nxt;
      col_r    <= col_r + 11'd1;
      remain_r <= remain_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_col_r  <= col_r;
      s1_row_r  <= row_r;
      s1_last_r <= (remain_r == CNT_W'(1));
      s2_col_r  <= s1_col_r;
      s2_row_r  <= s1_row_r;
      s2_last_r <= s1_last_r;
    end
  end

  // texel index from the integer parts of v and u
  assign tex_rd_addr = {v_r[FRAC_BITS +: TILE_BITS], u_r[FRAC_BITS +: TILE_BITS]};
  assign sh_rd_addr  = base_r + SH_AW'(tex_rd_data);

  fstm_ram #(
    .WIDTH (TVAL_W),
    .DEPTH (TILE_SIZE)
  ) u_tex_ram (
    .clk     (clk),
    .wr_en   (tex_wr_en),
    .wr_addr (TEX_AW'(in_ch.table_address)),
    .wr_data (in_ch.table_value),
    .rd_en   (step_go),
    .rd_addr (tex_rd_addr),
    .rd_data (tex_rd_data)
  );

  fstm_ram #(
    .WIDTH (COLOUR_W),
    .DEPTH (SHADE_SIZE)
  ) u_shade_ram (
    .clk     (clk),
    .wr_en   (sh_wr_en),
    .wr_addr (SH_AW'(in_ch.table_address)),
    .wr_data (in_ch.table_value),
    .rd_en   (advance && s1_valid_r),
    .rd_addr (sh_rd_addr),
    .rd_data (sh_rd_data)
  );

  assign out_ch.valid        = s2_valid_r;
  assign out_ch.pixel_column = s2_col_r;
  assign out_ch.pixel_row    = s2_row_r;
  assign out_ch.pixel_colour = sh_rd_data;
  assign out_ch.last_pixel   = s2_last_r;

  // a stalled result keeps its colour and column
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> ($stable(sh_rd_data) && $stable(s2_col_r)))
    else $error("stalled result changed");

  // the last pixel in the texel stage means the walker has finished
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_last_r) |-> (state_r == ST_IDLE))
    else $error("walker active behind last pixel");

  // walking always has pixels left
  a_walk_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (remain_r != '0))
    else $error("walk with zero pixels left");

  // a draw with pixels starts the walker
  a_draw_walks: assert property (@(posedge clk) disable iff (!rst_n)
    draw_start |=> (state_r == ST_WALK))
    else $error("draw request did not start walker");

endmodule

`default_nettype wire

@@ src/fstm_ram.sv @@
// Generic single-write, single-read RAM with registered, enabled read.
`default_nettype none

module fstm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]              rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ test/flat_span_texture_mapper_checker.sv @@
// Span mapper checker: watches both channels, predicts pixel requests, compares.
`default_nettype none

module flat_span_texture_mapper_checker import fstm_pkg::*; #(
  parameter int SPAN_MAX     = 64,
  parameter int SHADE_TABLES = 32,
  parameter int TILE_BITS    = 6
) (
  input  wire logic clk,
  input  wire logic rst_n,
  fstm_in_if        in_ch,
  fstm_out_if       out_ch,
  output int        fail_count,
  output int        pending
);

  localparam int unsigned TILE_MASK  = (1 << TILE_BITS) - 1;
  localparam int unsigned TILE_SIZE  = 1 << (2 * TILE_BITS);
  localparam int unsigned SHADE_SIZE = 256 * SHADE_TABLES;
  localparam int          REPORT_MAX = 10;

  typedef struct packed {
    logic [COL_W-1:0]    column;
    logic [ROW_W-1:0]    row;
    logic [COLOUR_W-1:0] colour;
    logic                last;
  } pixel_t;

  logic [TVAL_W-1:0] tile_mem  [TILE_SIZE];
  logic [TVAL_W-1:0] shade_mem [SHADE_SIZE];
  pixel_t            pixel_q   [$];
  int                mismatches;
  int                depth;

  assign fail_count = mismatches;
  assign pending    = depth;

  initial begin
    mismatches = 0;
    depth      = 0;
    foreach (tile_mem[i]) tile_mem[i] = '0;
    foreach (shade_mem[i]) shade_mem[i] = '0;
  end

  function automatic int unsigned tile_index(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
    int unsigned r;
    int unsigned c;
    r = (v >> (FRAC_BITS - TILE_BITS)) & (TILE_MASK << TILE_BITS);
    c = (u >> FRAC_BITS) & TILE_MASK;
    return (r + c) & (TILE_SIZE - 1);
  endfunction

  // Expected pixels of one span, in walk order
  function automatic void walk_span(logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                                    logic [COUNT_W-1:0] count,
                                    logic [COORD_W-1:0] u, logic [COORD_W-1:0] v,
                                    logic [COORD_W-1:0] du, logic [COORD_W-1:0] dv,
                                    logic [SEL_W-1:0] sel);
    int unsigned n;
    int unsigned table_sel;
    int unsigned t;
    int unsigned s;
    pixel_t      px;
    n = count;
    if (n > SPAN_MAX) n = SPAN_MAX;
    table_sel = sel;
    if (table_sel >= SHADE_TABLES) table_sel = SHADE_TABLES - 1;
    for (int unsigned k = 0; k < n; k++) begin
      t         = tile_index(u, v);
      s         = (table_sel * 256 + tile_mem[t]) % SHADE_SIZE;
      px.column = col + COL_W'(k);
      px.row    = row;
      px.colour = shade_mem[s];
      px.last   = (k + 1 == n);
      pixel_q.push_back(px);
      u = u + du;
      v = v + dv;
    end
  endfunction

  // Sampled mid-cycle: everything is settled, the transfer happens at the next edge
  always @(negedge clk) begin : monitor
    pixel_t got;
    pixel_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.pixel_column, out_ch.pixel_row, out_ch.pixel_colour, out_ch.last_pixel};
        if (pixel_q.size() == 0) begin
          if (mismatches < REPORT_MAX)
            $display("unexpected pixel: col %0d row %0d colour %0h last %0b",
                     got.column, got.row, got.colour, got.last);
          mismatches++;
        end else begin
          want = pixel_q.pop_front();
          if (got !== want) begin
            if (mismatches < REPORT_MAX)
              $display("pixel mismatch (exp/got): col %0d/%0d row %0d/%0d colour %0h/%0h last %0b/%0b",
                       want.column, got.column, want.row, got.row,
                       want.colour, got.colour, want.last, got.last);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.operation)
          OP_LOAD_TEXEL: if (in_ch.table_address < TILE_SIZE)
                           tile_mem[in_ch.table_address] = in_ch.table_value;
          OP_LOAD_SHADE: if (in_ch.table_address < SHADE_SIZE)
                           shade_mem[in_ch.table_address] = in_ch.table_value;
          OP_DRAW:       walk_span(in_ch.span_row, in_ch.first_column, in_ch.pixel_count,
                                   in_ch.start_u, in_ch.start_v, in_ch.step_u, in_ch.step_v,
                                   in_ch.shade_select);
          default: ;
        endcase
      end
    end
    depth = pixel_q.size();
  end

endmodule

`default_nettype wire

@@ test/flat_span_texture_mapper_core_tb.sv @@
// Testbench top of the span mapper: clock, reset, request stimulus and verdict.
`default_nettype none

module flat_span_texture_mapper_core_tb;
  import fstm_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 7;
  localparam int SPAN_MAX       = 64;
  localparam int SHADE_TABLES   = 32;
  localparam int TILE_BITS      = 6;
  localparam int TOTAL_ITEMS    = 130;  // least number of requests accepted over the whole run
  localparam int PRESSURE_AT    = 100;  // request count at which the long hold-off starts
  localparam int HOLD_CYCLES    = 400;  // long receiver hold-off, fills the block
  localparam int DRAIN_CYCLES   = 16;   // slack after the last expected pixel
  localparam int WATCHDOG_LIMIT = 5000; // cycles with no transfer on either channel

  localparam int unsigned TILE_MASK  = (1 << TILE_BITS) - 1;
  localparam int unsigned TILE_SIZE  = 1 << (2 * TILE_BITS);
  localparam int unsigned SHADE_SIZE = 256 * SHADE_TABLES;

  // The one code the block must drop
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef enum int {
    PH_FREE,        // no idling on either side
    PH_SEND_IDLE,   // sender holds off with chance 65 in 100
    PH_RECV_STALL,  // receiver stalls with chance 65 in 100
    PH_BOTH         // both sides at chance 27 in 100
  } idle_phase_t;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [TADDR_W-1:0] addr;
    logic [TVAL_W-1:0]  val;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [COUNT_W-1:0] count;
    logic [COORD_W-1:0] u;
    logic [COORD_W-1:0] v;
    logic [COORD_W-1:0] du;
    logic [COORD_W-1:0] dv;
    logic [SEL_W-1:0]   sel;
  } span_req_t;

  logic        clk;
  logic        rst_n;
  idle_phase_t phase;
  int          hold_asks;   // bumped by stimulus, each bump asks for one long hold-off
  int          sent_items;  // requests accepted so far
  int          fail_count;
  int          pending;

  // Which table entries hold defined data; a draw never reads anything else
  bit                tex_written   [TILE_SIZE];
  logic [TVAL_W-1:0] tex_val       [TILE_SIZE];
  bit                shade_written [SHADE_SIZE];

  fstm_in_if  in_ch ();
  fstm_out_if out_ch ();

  flat_span_texture_mapper_core #(
    .SPAN_MAX     (SPAN_MAX),
    .SHADE_TABLES (SHADE_TABLES),
    .TILE_BITS    (TILE_BITS)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  flat_span_texture_mapper_checker #(
    .SPAN_MAX     (SPAN_MAX),
    .SHADE_TABLES (SHADE_TABLES),
    .TILE_BITS    (TILE_BITS)
  ) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic bit sender_waits();
    case (phase)
      PH_SEND_IDLE: return $urandom_range(0, 99) < 65;
      PH_BOTH:      return $urandom_range(0, 99) < 27;
      default:      return 1'b0;
    endcase
  endfunction

  // Every field but the operation random, so unused fields of a request toggle too
  function automatic span_req_t random_req();
    span_req_t r;
    r.op    = OP_DRAW;
    r.addr  = TADDR_W'($urandom);
    r.val   = TVAL_W'($urandom);
    r.row   = ROW_W'($urandom);
    r.col   = COL_W'($urandom);
    r.count = COUNT_W'($urandom);
    r.u     = $urandom;
    r.v     = $urandom;
    r.du    = $urandom;
    r.dv    = $urandom;
    r.sel   = SEL_W'($urandom);
    return r;
  endfunction

  function automatic span_req_t make_draw(int unsigned row, int unsigned col, int unsigned count,
                                          logic [COORD_W-1:0] u, logic [COORD_W-1:0] v,
                                          logic [COORD_W-1:0] du, logic [COORD_W-1:0] dv,
                                          int unsigned sel);
    span_req_t r;
    r       = random_req();
    r.row   = ROW_W'(row);
    r.col   = COL_W'(col);
    r.count = COUNT_W'(count);
    r.u     = u;
    r.v     = v;
    r.du    = du;
    r.dv    = dv;
    r.sel   = SEL_W'(sel);
    return r;
  endfunction

  function automatic int unsigned texel_at(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
    return (((v >> (FRAC_BITS - TILE_BITS)) & (TILE_MASK << TILE_BITS))
            + ((u >> FRAC_BITS) & TILE_MASK)) & (TILE_SIZE - 1);
  endfunction

  // Texels take one of a few values, so each shade table needs few entries
  function automatic logic [TVAL_W-1:0] texel_pick();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'h5C;
      2:       return 8'hA3;
      default: return 8'hFF;
    endcase
  endfunction

  // Drive one request and hold it until the block takes it. Called and
  // returning on a rising edge; ready is sampled mid-cycle.
  task automatic send_req(input span_req_t r);
    while (sender_waits()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= r.op;
    in_ch.table_address <= r.addr;
    in_ch.table_value   <= r.val;
    in_ch.span_row      <= r.row;
    in_ch.first_column  <= r.col;
    in_ch.pixel_count   <= r.count;
    in_ch.start_u       <= r.u;
    in_ch.start_v       <= r.v;
    in_ch.step_u        <= r.du;
    in_ch.step_v        <= r.dv;
    in_ch.shade_select  <= r.sel;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    sent_items++;
    // keep track of which entries are now defined
    if (r.op == OP_LOAD_TEXEL && r.addr < TILE_SIZE) begin
      tex_written[r.addr] = 1'b1;
      tex_val[r.addr]     = r.val;
    end
    if (r.op == OP_LOAD_SHADE && r.addr < SHADE_SIZE)
      shade_written[r.addr] = 1'b1;
  endtask

  task automatic send_load(input logic [OP_W-1:0] op, input int unsigned addr,
                           input logic [TVAL_W-1:0] val);
    span_req_t r;
    r      = random_req();
    r.op   = op;
    r.addr = TADDR_W'(addr);
    r.val  = val;
    send_req(r);
  endtask

  // Walk the span ahead of time and load every texel and shade entry it
  // would read that is still undefined, then issue the draw itself.
  task automatic prime_and_draw(input span_req_t r);
    int unsigned        n;
    int unsigned        table_sel;
    int unsigned        t;
    int unsigned        s;
    logic [COORD_W-1:0] u;
    logic [COORD_W-1:0] v;
    r.op      = OP_DRAW;
    n         = (r.count > SPAN_MAX) ? SPAN_MAX : r.count;
    table_sel = (r.sel >= SHADE_TABLES) ? SHADE_TABLES - 1 : r.sel;
    u         = r.u;
    v         = r.v;
    for (int unsigned k = 0; k < n; k++) begin
      t = texel_at(u, v);
      if (!tex_written[t]) send_load(OP_LOAD_TEXEL, t, texel_pick());
      s = (table_sel * 256 + tex_val[t]) % SHADE_SIZE;
      if (!shade_written[s]) send_load(OP_LOAD_SHADE, s, TVAL_W'($urandom));
      u = u + r.du;
      v = v + r.dv;
    end
    send_req(r);
  endtask

  // Random draw: mostly short spans with small steps near one corner of the
  // tile, some long or saturated spans, and a few short spans with fully
  // random steps that jump across the tile.
  function automatic span_req_t random_draw();
    span_req_t r;
    int        pick;
    r    = random_req();
    pick = $urandom_range(0, 9);
    if (pick < 6)      r.count = COUNT_W'($urandom_range(1, 16));
    else if (pick < 8) r.count = COUNT_W'($urandom_range(17, SPAN_MAX));
    else               r.count = COUNT_W'($urandom_range(SPAN_MAX + 1, (1 << COUNT_W) - 1));
    r.u[FRAC_BITS +: TILE_BITS] = TILE_BITS'($urandom_range(0, 7));
    r.v[FRAC_BITS +: TILE_BITS] = TILE_BITS'($urandom_range(0, 7));
    if ($urandom_range(0, 3) != 0) begin
      r.du = $urandom_range(0, 32'h1FFF) - 32'h1000;
      r.dv = $urandom_range(0, 32'h1FFF) - 32'h1000;
    end else begin
      r.count = COUNT_W'($urandom_range(1, 4));
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stalls per phase, plus one long hold-off on request.
  // The hold-off is counted here, while the sender keeps offering.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        case (phase)
          PH_RECV_STALL: out_ch.ready <= ($urandom_range(0, 99) >= 65);
          PH_BOTH:       out_ch.ready <= ($urandom_range(0, 99) >= 27);
          default:       out_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run once no request has moved on either channel for
  // the quiet span that WATCHDOG_LIMIT sets.
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    span_req_t   r;
    int          pick;
    int unsigned addr;
    bit          pressure_done;

    phase         = PH_FREE;
    hold_asks     = 0;
    sent_items    = 0;
    pressure_done = 1'b0;

    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.operation     <= OP_DRAW;
    in_ch.table_address <= '0;
    in_ch.table_value   <= '0;
    in_ch.span_row      <= '0;
    in_ch.first_column  <= '0;
    in_ch.pixel_count   <= '0;
    in_ch.start_u       <= '0;
    in_ch.start_v       <= '0;
    in_ch.step_u        <= '0;
    in_ch.step_v        <= '0;
    in_ch.shade_select  <= '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // tile corners and both ends of the shade store
    send_load(OP_LOAD_TEXEL, 0, 8'h00);
    send_load(OP_LOAD_TEXEL, TILE_SIZE - 1, 8'hFF);
    // loads past the tile are dropped; values differ so an aliased write shows
    send_load(OP_LOAD_TEXEL, TILE_SIZE, 8'h5A);
    send_load(OP_LOAD_TEXEL, (1 << TADDR_W) - 1, 8'hA5);
    send_load(OP_LOAD_SHADE, 0, 8'h00);
    send_load(OP_LOAD_SHADE, SHADE_SIZE - 1, 8'hFF);
    // unused operation code and empty span: no pixel
    r    = random_req();
    r.op = OP_UNUSED;
    send_req(r);
    prime_and_draw(make_draw(9, 9, 0, 0, 0, 0, 0, 0));
    // single pixels at the corners of the tile, table 0 and last table
    prime_and_draw(make_draw(0, 0, 1, 0, 0, 0, 0, 0));
    prime_and_draw(make_draw(1023, 2047, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 31));
    // most negative coordinates and steps, column wrap after the first pixel
    prime_and_draw(make_draw(512, 2047, 2, 32'h8000_0000, 32'h8000_0000,
                             32'h8000_0000, 32'h8000_0000, 0));
    // full span down the tile diagonal at a quarter texel per pixel, column wraps
    prime_and_draw(make_draw(7, 2000, SPAN_MAX, 0, 0, 32'h0000_4000, 32'h0000_4000, 3));
    // counts above the maximum saturate
    prime_and_draw(make_draw(100, 5, (1 << COUNT_W) - 1, $urandom, $urandom,
                             32'h7FFF_FFFF, 32'h8000_0000, 31));
    prime_and_draw(make_draw(200, 1000, SPAN_MAX + 1, $urandom, $urandom,
                             32'hFFFF_C000, 32'h0000_0800, 17));
    // texel load right before the draw that reads it
    send_load(OP_LOAD_SHADE, 8'h11, 8'h77);
    send_load(OP_LOAD_TEXEL, 0, 8'h11);
    prime_and_draw(make_draw(3, 3, 1, 0, 0, 0, 0, 0));
    // texel overwritten right after a span that reads it
    send_load(OP_LOAD_SHADE, 8'h22, 8'h44);
    prime_and_draw(make_draw(4, 4, 8, 0, 0, 0, 0, 0));
    send_load(OP_LOAD_TEXEL, 0, 8'h22);
    prime_and_draw(make_draw(5, 5, 1, 0, 0, 0, 0, 0));

    // --- random part ---
    // Mostly well-formed draws (with their table loads), plus stray loads,
    // loads past the tile, unused codes and empty spans.
    while (sent_items < TOTAL_ITEMS || !pressure_done) begin
      if (sent_items < 75)       phase = PH_FREE;
      else if (sent_items < 95)  phase = PH_SEND_IDLE;
      else if (sent_items < 115) phase = PH_RECV_STALL;
      else                       phase = PH_BOTH;
      // long receiver hold-off; the second span waits behind the held pixels
      if (!pressure_done && sent_items >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        hold_asks++;
        prime_and_draw(random_draw());
        prime_and_draw(random_draw());
      end
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        prime_and_draw(random_draw());
      end else if (pick < 85) begin
        addr = $urandom_range(0, (1 << TADDR_W) - 1);
        send_load(OP_LOAD_TEXEL, addr, TVAL_W'($urandom));
      end else if (pick < 90) begin
        send_load(OP_LOAD_SHADE, $urandom_range(0, SHADE_SIZE - 1), TVAL_W'($urandom));
      end else if (pick < 95) begin
        r    = random_req();
        r.op = OP_UNUSED;
        send_req(r);
      end else begin
        r       = random_req();
        r.count = '0;
        prime_and_draw(r);
      end
    end

    // --- drain ---
    in_ch.valid <= 1'b0;
    phase = PH_FREE;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
